### rtl/scld_pkg.sv
// ----------------------------------------------------------------------------
// scld_pkg
// Shared types and constants of the serial command line decoder.
// ----------------------------------------------------------------------------
package scld_pkg;

  localparam logic [2:0] StOn      = 3'd0;
  localparam logic [2:0] StOff     = 3'd1;
  localparam logic [2:0] StAuto    = 3'd2;
  localparam logic [2:0] StHelp    = 3'd3;
  localparam logic [2:0] StPwm     = 3'd4;
  localparam logic [2:0] StRange   = 3'd5;
  localparam logic [2:0] StUnknown = 3'd6;
  localparam logic [2:0] StIgnored = 3'd7;

  localparam logic [7:0] ChCr    = 8'd13;
  localparam logic [7:0] ChLf    = 8'd10;
  localparam logic [7:0] ChSpace = 8'd32;

  localparam logic [0:0] RegLevelMin = 1'b0;
  localparam logic [0:0] RegLevelMax = 1'b1;

  // word matcher progress
  typedef enum logic [2:0] {
    WdNone = 3'd0,
    WdO    = 3'd1,
    WdOn   = 3'd2,
    WdOf   = 3'd3,
    WdOff  = 3'd4
  } wd_o_e;

  // what a scan step has learnt about one character
  typedef struct packed {
    logic       is_space;
    logic       is_digit;
    logic       is_alnum;
    logic [7:0] upper;
  } char_info_t;

  function automatic char_info_t classify(input logic [7:0] c);
    char_info_t r;
    r.upper    = (c >= 8'h61 && c <= 8'h7a) ? c - 8'd32 : c;
    r.is_space = (r.upper == ChSpace);
    r.is_digit = (r.upper >= 8'h30 && r.upper <= 8'h39);
    r.is_alnum = r.is_digit || (r.upper >= 8'h41 && r.upper <= 8'h5a);
    return r;
  endfunction

endpackage

### rtl/serial_command_line_decoder.sv
// ----------------------------------------------------------------------------
// serial_command_line_decoder
// Gathers received bytes into a line memory and decodes text commands.
// ----------------------------------------------------------------------------
// Use:
//   s_axis carries one received byte per transaction. Bytes are written to a
//   line memory of LINE_BYTES-1 entries; surplus bytes are dropped. CR or LF
//   on a nonempty line starts a decode walk that reads the memory one entry
//   per cycle (registered read port) into a character-serial parser.
//   m_axis then carries one result: status, on flag, auto flag, level.
//   Empty-line terminators give no result.
// Rate: ordinary bytes are accepted one per cycle while idle. A line end
//   starts a walk that reads each stored byte in turn, then drains the
//   registered read and takes the verdict, paced by the single read port.
//   No byte is accepted during a walk or while a result is held.
// Reset: line empty, on flag 0, auto flag 1, level 0, limits 0 and 255.
// Stall: the result stays in the output register until m_axis_tready; input
//   is held off meanwhile.
// Config: cfg_we_i writes level_min (index 0) or level_max (index 1).
// ----------------------------------------------------------------------------
module serial_command_line_decoder #(
  parameter int unsigned LINE_BYTES = 40
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [2:0] status, [3] output_on,
                                      // [4] auto_mode, [12:5] manual_level
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [7:0]  cfg_data_i
);
  localparam int unsigned Depth = LINE_BYTES - 1;
  localparam int unsigned AW    = $clog2(LINE_BYTES);

  typedef enum logic [3:0] {
    SIdle  = 4'b0001,
    SWalk  = 4'b0010,
    SDrain = 4'b0100,
    SOut   = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic [AW-1:0] len_q, rd_q;
  logic [7:0] lmin_q, lmax_q, level_q;
  logic on_q, auto_q, stop_q, rdv_q;
  logic [15:0] out_q;

  logic acc, eol, we;
  logic [7:0] rdata;
  logic [2:0] st;
  logic [7:0] val;
  logic on_d, auto_d;
  logic [7:0] level_d;

  assign acc = s_axis_tvalid && s_axis_tready;
  assign eol = (s_axis_tdata == scld_pkg::ChCr) || (s_axis_tdata == scld_pkg::ChLf);
  assign we  = acc && !eol && (len_q < AW'(Depth));
  assign s_axis_tready = (state_q == SIdle);
  assign m_axis_tvalid = (state_q == SOut);
  assign m_axis_tdata  = out_q;

  scld_store #(.Depth(Depth), .AW(AW)) u_store (
    .clk_i, .we_i(we), .waddr_i(len_q), .wdata_i(s_axis_tdata),
    .raddr_i(rd_q), .rdata_o(rdata)
  );

  // a zero byte ends the content; later reads are discarded
  logic ch_vld;
  assign ch_vld = rdv_q && !stop_q && (rdata != 8'd0);

  scld_parse u_parse (
    .clk_i, .rst_ni,
    .start_i(acc), .ch_vld_i(ch_vld), .ch_i(rdata),
    .level_min_i(lmin_q), .level_max_i(lmax_q),
    .status_o(st), .value_o(val)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      SIdle:   if (acc && eol && len_q != '0) state_d = SWalk;
      SWalk:   if (rd_q == len_q - AW'(1)) state_d = SDrain;
      SDrain:  if (!rdv_q) state_d = SOut;
      SOut:    if (m_axis_tready) state_d = SIdle;
      default: state_d = SIdle;
    endcase
  end

  // settings after the verdict
  always_comb begin
    on_d    = on_q;
    auto_d  = auto_q;
    level_d = level_q;
    case (st)
      scld_pkg::StOn:   on_d = 1'b1;
      scld_pkg::StOff:  on_d = 1'b0;
      scld_pkg::StAuto: auto_d = 1'b1;
      scld_pkg::StPwm: begin
        auto_d  = 1'b0;
        level_d = val;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle; len_q <= '0; rd_q <= '0; rdv_q <= 1'b0; stop_q <= 1'b0;
      lmin_q <= 8'd0; lmax_q <= 8'd255; on_q <= 1'b0; auto_q <= 1'b1;
      level_q <= 8'd0; out_q <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        if (cfg_idx_i == scld_pkg::RegLevelMin) lmin_q <= cfg_data_i;
        else lmax_q <= cfg_data_i;
      end
      if (we) len_q <= len_q + AW'(1);
      rdv_q <= (state_q == SWalk);
      if (state_q == SIdle) begin
        rd_q <= '0; stop_q <= 1'b0;
      end
      if (state_q == SWalk) rd_q <= rd_q + AW'(1);
      if (rdv_q && rdata == 8'd0) stop_q <= 1'b1;
      if (state_q == SDrain && !rdv_q) begin
        len_q   <= '0;
        on_q    <= on_d;
        auto_q  <= auto_d;
        level_q <= level_d;
        out_q   <= {3'b000, level_d, auto_d, on_d, st};
      end
    end
  end
endmodule

### rtl/scld_store.sv
// ----------------------------------------------------------------------------
// scld_store
// Line memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module scld_store #(
  parameter int unsigned Depth = 39,
  parameter int unsigned AW    = 6
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [7:0]    rdata_o
);
  logic [7:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

### rtl/scld_parse.sv
// ----------------------------------------------------------------------------
// scld_parse
// Character-serial line parser: one stored byte per cycle, then a verdict.
// ----------------------------------------------------------------------------
module scld_parse (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,   // clear parse state
  input  logic       ch_vld_i,  // content byte this cycle
  input  logic [7:0] ch_i,
  input  logic [7:0] level_min_i,
  input  logic [7:0] level_max_i,
  output logic [2:0] status_o,  // verdict on the bytes consumed so far
  output logic [7:0] value_o
);
  // tokens: word chars since last space, whole line as pending spaces
  logic       seen_q, bad_q, pend_sp_q;
  logic [2:0] pos_q;            // first-word chars consumed, saturating at 7
  logic       multi_q;          // a second word started
  logic [31:0] w1_sh_q;         // first word, last 4 chars
  logic       dig_q, dig_done_q, sp_after_q;
  logic [8:0] val_q;
  logic       first_end_q;      // first word closed by a space

  scld_pkg::char_info_t ci;
  assign ci = scld_pkg::classify(ch_i);

  logic [8:0] nv;
  always_comb begin
    logic [12:0] t;
    t  = {4'd0, val_q} * 13'd10 + {9'd0, ci.upper[3:0]};
    nv = (t > 13'd256) ? 9'd256 : t[8:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= 1'b0; bad_q <= 1'b0; pend_sp_q <= 1'b0; pos_q <= '0;
      multi_q <= 1'b0; w1_sh_q <= '0; first_end_q <= 1'b0; dig_q <= 1'b0;
      dig_done_q <= 1'b0; val_q <= '0; sp_after_q <= 1'b0;
    end else if (start_i) begin
      seen_q <= 1'b0; bad_q <= 1'b0; pend_sp_q <= 1'b0; pos_q <= '0;
      multi_q <= 1'b0; w1_sh_q <= '0; first_end_q <= 1'b0; dig_q <= 1'b0;
      dig_done_q <= 1'b0; val_q <= '0; sp_after_q <= 1'b0;
    end else if (ch_vld_i) begin
      if (ci.is_space) begin
        if (seen_q) begin
          pend_sp_q <= 1'b1;
          first_end_q <= 1'b1;
        end
      end else begin
        seen_q    <= 1'b1;
        pend_sp_q <= 1'b0;
        if (!ci.is_alnum) bad_q <= 1'b1;
        if (!first_end_q) begin
          w1_sh_q <= {w1_sh_q[23:0], ci.upper};
          if (pos_q != 3'd7) pos_q <= pos_q + 3'd1;
        end else begin
          multi_q <= 1'b1;
          // digits of the PWM argument: only the first word after spaces
          if (!sp_after_q) begin
            sp_after_q <= 1'b1;
            dig_q      <= ci.is_digit;
            dig_done_q <= !ci.is_digit;
            if (ci.is_digit) val_q <= {5'd0, ci.upper[3:0]};
          end else if (!dig_done_q && !pend_sp_q) begin
            if (ci.is_digit) val_q <= nv;
            else dig_done_q <= 1'b1;
          end else dig_done_q <= 1'b1;
        end
      end
    end
  end

  // pending spaces after the argument do not matter for PWM; other words need
  // a single token so multi_q covers them. Trailing spaces are trimmed.
  logic is_pwm_w, is_on, is_off, is_auto, is_help;
  assign is_pwm_w = (pos_q == 3'd3) && (w1_sh_q[23:0] == 24'h50574d);
  assign is_on    = (pos_q == 3'd2) && (w1_sh_q[15:0] == 16'h4f4e);
  assign is_off   = (pos_q == 3'd3) && (w1_sh_q[23:0] == 24'h4f4646);
  assign is_auto  = (pos_q == 3'd4) && (w1_sh_q == 32'h4155544f);
  assign is_help  = (pos_q == 3'd4) && (w1_sh_q == 32'h48454c50);

  always_comb begin
    value_o = val_q[7:0];
    if (!seen_q || bad_q) status_o = scld_pkg::StIgnored;
    else if (is_pwm_w && multi_q && dig_q) begin
      if (val_q < {1'b0, level_min_i} || val_q > {1'b0, level_max_i})
        status_o = scld_pkg::StRange;
      else status_o = scld_pkg::StPwm;
    end else if (multi_q) status_o = scld_pkg::StUnknown;
    else if (is_on)   status_o = scld_pkg::StOn;
    else if (is_off)  status_o = scld_pkg::StOff;
    else if (is_auto) status_o = scld_pkg::StAuto;
    else if (is_help) status_o = scld_pkg::StHelp;
    else status_o = scld_pkg::StUnknown;
  end
endmodule

### rtl/scld_checker.sv
// ----------------------------------------------------------------------------
// scld_checker
// Port-level checks of the command line decoder.
// ----------------------------------------------------------------------------
module scld_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [7:0]  s_axis_tdata,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped under stall");
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(m_axis_tvalid && s_axis_tready))
    else $error("input open while result held");
  a_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[15:13] == 3'd0)
    else $error("padding bits set");
  a_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready |=> !m_axis_tvalid)
    else $error("result repeated");
  a_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid |-> !$isunknown(s_axis_tdata))
    else $error("unknown input byte");
endmodule

bind serial_command_line_decoder scld_checker u_scld_checker (
  .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
  .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
);
